// ===== hw/rtl/sobel_edge_magnitude_defines.svh =====
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_DEFINES_SVH

`ifndef SYNTHESIS
`define SEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SEM_ASSERT(lbl, prop, msg)
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/sem_pkg.sv =====
package sem_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 12;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int RAD_W   = 21;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_RIGHT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_BOTTOM   = 3'd5;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } sem_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             last_of_run;
  } sem_out_t;

  typedef logic [2:0][PIX_W-1:0] pix3_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sem_root_req_t;

endpackage

// ===== hw/rtl/sem_line_ram.sv =====
module sem_line_ram #(
  parameter int Depth = 2048,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sem_isqrt.sv =====
module sem_isqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sem_pkg::sem_root_req_t req_i,
  output logic                  done_o,
  output logic [7:0]            root_o
);
  import sem_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [2:0]  step_q, step_d;
  logic [7:0]  root_q, root_d;
  logic [15:0] val_q, val_d;
  logic [7:0]  trial;
  logic [15:0] trial_sq;

  assign trial    = root_q | (8'd1 << step_q);
  assign trial_sq = trial * trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    root_d = root_q;
    val_d  = val_q;
    if (req_i.start) begin
      if (req_i.radicand[RAD_W-1:16] != '0) begin
        root_d = 8'd255;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        step_d = 3'd7;
        root_d = '0;
        val_d  = req_i.radicand[15:0];
      end
    end else if (busy_q) begin
      if (trial_sq <= val_q) begin
        root_d = trial;
      end
      if (step_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
    val_q  <= val_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/sobel_edge_magnitude.sv =====
// 3x3 sobel edge magnitude over a raster pixel stream. one pixel is taken per
// transaction; it passes a line store read, then write back, and then the
// iterative square root unit once per result it produces, from none up to
// four (row end of the last row). results trail the input by one row and one
// column (at a row end and in the last row, results for the current column
// and row are added) and carry their coordinates; last_of_run marks the
// final result of a pixel. the line store holds the two previous rows in one
// memory whose contents are undefined after reset; no clearing pass is run.
`include "sobel_edge_magnitude_defines.svh"

module sobel_edge_magnitude #(
  parameter int MaxWidth  = sem_pkg::MAX_WIDTH,
  parameter int MaxHeight = sem_pkg::MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sem_pkg::sem_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sem_pkg::sem_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import sem_pkg::*;

  localparam int CW = $clog2(MaxWidth);
  localparam int RW = $clog2(MaxHeight);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SUMS  = 3'd2;
  localparam logic [2:0] S_SQR   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_ROOT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;

  // configuration
  logic [11:0] img_w_q, roi_l_q, roi_r_q;
  logic [12:0] img_h_q, roi_t_q, roi_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 12'd640;
      img_h_q <= 13'd480;
      roi_l_q <= '0;
      roi_t_q <= '0;
      roi_r_q <= 12'd2048;
      roi_b_q <= 13'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  img_w_q <= cfg_wdata_i[11:0];
        REG_IMAGE_HEIGHT: img_h_q <= cfg_wdata_i;
        REG_ROI_LEFT:     roi_l_q <= cfg_wdata_i[11:0];
        REG_ROI_TOP:      roi_t_q <= cfg_wdata_i;
        REG_ROI_RIGHT:    roi_r_q <= cfg_wdata_i[11:0];
        REG_ROI_BOTTOM:   roi_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [CW:0] w_eff;
  logic [RW:0] h_eff;

  always_comb begin
    if (img_w_q == '0) begin
      w_eff = (CW+1)'(1);
    end else if (img_w_q > MaxWidth) begin
      w_eff = (CW+1)'(MaxWidth);
    end else begin
      w_eff = (CW+1)'(img_w_q);
    end
    if (img_h_q == '0) begin
      h_eff = (RW+1)'(1);
    end else if (img_h_q > MaxHeight) begin
      h_eff = (RW+1)'(MaxHeight);
    end else begin
      h_eff = (RW+1)'(img_h_q);
    end
  end

  // position of the incoming pixel
  logic [CW-1:0] col_cnt_q, col_cnt_d;
  logic [RW-1:0] row_cnt_q, row_cnt_d;
  logic [CW:0]   cc, nc;
  logic [RW:0]   rr, nr;
  logic          accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cc = in_data_i.frame_start ? '0 : {1'b0, col_cnt_q};
    rr = in_data_i.frame_start ? '0 : {1'b0, row_cnt_q};
    if (cc >= w_eff) begin
      cc = '0;
      rr = rr + 1'b1;
    end
    if (rr >= h_eff) begin
      rr = '0;
    end
    nc = cc + 1'b1;
    nr = rr;
    if (nc >= w_eff) begin
      nc = '0;
      nr = rr + 1'b1;
      if (nr >= h_eff) begin
        nr = '0;
      end
    end
    col_cnt_d = accept ? nc[CW-1:0] : col_cnt_q;
    row_cnt_d = accept ? nr[RW-1:0] : row_cnt_q;
  end

  // latched per pixel
  logic [CW-1:0]    cur_c_q;
  logic [RW-1:0]    cur_r_q;
  logic [PIX_W-1:0] px_q;
  logic             last_row_q, c_last_q, c_ge1_q, c_ge2_q, r_is0_q, r_is1_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_c_q    <= cc[CW-1:0];
      cur_r_q    <= rr[RW-1:0];
      px_q       <= in_data_i.pixel_in;
      last_row_q <= (rr == h_eff - 1'b1);
      c_last_q   <= (cc == w_eff - 1'b1);
      c_ge1_q    <= (cc != '0);
      c_ge2_q    <= (cc >= (CW+1)'(2));
      r_is0_q    <= (rr == '0);
      r_is1_q    <= (rr == (RW+1)'(1));
    end
  end

  // line store: upper row in the high byte, lower row in the low byte
  logic [2*PIX_W-1:0] ram_rdata;
  logic               ram_we;

  assign ram_we = (state_q == S_READ);

  sem_line_ram #(
    .Depth (MaxWidth),
    .Width (2*PIX_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_c_q),
    .wdata_i ({ram_rdata[PIX_W-1:0], px_q}),
    .re_i    (accept),
    .raddr_i (cc[CW-1:0]),
    .rdata_o (ram_rdata)
  );

  pix3_t stack;

  always_comb begin
    if (r_is0_q) begin
      stack[0] = px_q;
      stack[1] = px_q;
    end else if (r_is1_q) begin
      stack[0] = ram_rdata[PIX_W-1:0];
      stack[1] = ram_rdata[PIX_W-1:0];
    end else begin
      stack[0] = ram_rdata[2*PIX_W-1:PIX_W];
      stack[1] = ram_rdata[PIX_W-1:0];
    end
    stack[2] = px_q;
  end

  // column window: win0 newest column, win3 the one before
  pix3_t win0_q, win3_q, old3_q;
  logic [3:0] pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q <= '0;
      win3_q <= '0;
    end else if (state_q == S_READ) begin
      win3_q <= win0_q;
      win0_q <= stack;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      old3_q <= win3_q;
    end
  end

  // result selection
  logic [1:0] idx;
  logic [3:0] bit_sel;
  pix3_t      sl, sm, sr;
  logic [1:0] ti, ci, bi;

  always_comb begin
    if (pend_q[0]) begin
      idx = 2'd0;
    end else if (pend_q[1]) begin
      idx = 2'd1;
    end else if (pend_q[2]) begin
      idx = 2'd2;
    end else begin
      idx = 2'd3;
    end
    bit_sel = 4'd1 << idx;
    if (!idx[1]) begin
      sl = c_ge2_q ? old3_q : win3_q;
      sm = win3_q;
      sr = win0_q;
    end else begin
      sl = c_ge1_q ? win3_q : win0_q;
      sm = win0_q;
      sr = win0_q;
    end
    if (!idx[0]) begin
      ti = 2'd0;
      ci = 2'd1;
      bi = 2'd2;
    end else begin
      ti = 2'd1;
      ci = 2'd2;
      bi = 2'd2;
    end
  end

  logic signed [11:0] lt, lc, lb, mt, mb, rt, rc, rb, sx_d, sy_d;
  logic [CW-1:0]      ocol_d;
  logic [RW-1:0]      orow_d;

  always_comb begin
    lt = $signed({4'b0, sl[ti]});
    lc = $signed({4'b0, sl[ci]});
    lb = $signed({4'b0, sl[bi]});
    mt = $signed({4'b0, sm[ti]});
    mb = $signed({4'b0, sm[bi]});
    rt = $signed({4'b0, sr[ti]});
    rc = $signed({4'b0, sr[ci]});
    rb = $signed({4'b0, sr[bi]});
    sx_d = (rt - lt) + ((rc - lc) <<< 1) + (rb - lb);
    sy_d = (lb + (mb <<< 1) + rb) - (lt + (mt <<< 1) + rt);
    ocol_d = idx[1] ? cur_c_q : cur_c_q - 1'b1;
    orow_d = idx[0] ? cur_r_q : cur_r_q - 1'b1;
  end

  logic signed [11:0] sx_q, sy_q;
  logic [CW-1:0]      ocol_q;
  logic [RW-1:0]      orow_q;
  logic [PIX_W-1:0]   pass_q;
  logic               inroi_q, last_q;
  logic signed [23:0] sxp, syp;
  logic [19:0]        sxsq_q, sysq_q;

  assign sxp = sx_q * sx_q;
  assign syp = sy_q * sy_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SUMS) begin
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      ocol_q  <= ocol_d;
      orow_q  <= orow_d;
      pass_q  <= sm[ci];
      last_q  <= ((pend_q & ~bit_sel) == '0);
      inroi_q <= (ocol_d >= roi_l_q) && (ocol_d < roi_r_q) && (ocol_d < w_eff) &&
                 (orow_d >= roi_t_q) && (orow_d < roi_b_q) && (orow_d < h_eff);
    end
    if (state_q == S_SQR) begin
      sxsq_q <= sxp[19:0];
      sysq_q <= syp[19:0];
    end
  end

  sem_root_req_t root_req;
  logic          root_done;
  logic [7:0]    root;

  assign root_req.start    = (state_q == S_START);
  assign root_req.radicand = RAD_W'(sxsq_q) + RAD_W'(sysq_q);

  sem_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .done_o (root_done),
    .root_o (root)
  );

  // output register
  logic     out_valid_q, out_valid_d;
  sem_out_t out_q;
  logic     out_load;

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pixel_out   <= inroi_q ? root : pass_q;
      out_q.out_col     <= COL_W'(ocol_q);
      out_q.out_row     <= ROW_W'(orow_q);
      out_q.last_of_run <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        pend_d[0] = c_ge1_q && !r_is0_q;
        pend_d[1] = c_ge1_q && last_row_q;
        pend_d[2] = c_last_q && !r_is0_q;
        pend_d[3] = c_last_q && last_row_q;
        state_d   = (pend_d != '0) ? S_SUMS : S_IDLE;
      end
      S_SUMS: begin
        pend_d  = pend_q & ~bit_sel;
        state_d = S_SQR;
      end
      S_SQR:   state_d = S_START;
      S_START: state_d = S_ROOT;
      S_ROOT: begin
        if (root_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = (pend_q != '0) ? S_SUMS : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        pend_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= '0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      col_cnt_q   <= col_cnt_d;
      row_cnt_q   <= row_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `SEM_ASSERT(a_idle_no_pending, (state_q != S_IDLE) || (pend_q == '0), "pending results in idle")
  `SEM_ASSERT(a_root_done_in_wait, !root_done || (state_q == S_ROOT), "root done outside wait")
  `SEM_ASSERT_NEXT(a_accept_reads, accept, state_q == S_READ, "accept did not start a read")
  `SEM_ASSERT_NEXT(a_last_ends_run, out_load && last_q, state_q == S_IDLE, "run continued after last")

endmodule

// ===== sim/tb_sobel_edge_magnitude.sv =====
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude;
  import sem_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 20000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  sem_in_t        in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  sem_out_t       out_data_o;
  logic           cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  sobel_edge_magnitude u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // model state
  int unsigned   reg_val [6];
  logic [7:0]    row_upper [MAX_WIDTH];
  logic [7:0]    row_lower [MAX_WIDTH];
  pix3_t         win_cur, win_prev;
  int unsigned   col_pos, row_pos;
  sem_out_t      edge_q [$];

  int            err_count = 0;
  int            in_idle = 0;
  int            out_idle = 0;
  int            stall_cycles = 0;
  logic          moved = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_idle);
  end

  function automatic int unsigned eff_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic logic [7:0] root_sat(int unsigned v);
    int unsigned root, t;
    root = 0;
    if (v >= 65536) return 8'd255;
    for (int b = 7; b >= 0; b--) begin
      t = root | (1 << b);
      if (t * t <= v) root = t;
    end
    return root[7:0];
  endfunction

  task automatic push_edge(pix3_t l, pix3_t m, pix3_t r, int t, int c, int b,
                           int unsigned col, int unsigned row);
    int unsigned w, h, re, be;
    int sx, sy;
    sem_out_t o;
    w  = eff_dim(reg_val[REG_IMAGE_WIDTH], MAX_WIDTH);
    h  = eff_dim(reg_val[REG_IMAGE_HEIGHT], MAX_HEIGHT);
    re = (reg_val[REG_ROI_RIGHT] < w) ? reg_val[REG_ROI_RIGHT] : w;
    be = (reg_val[REG_ROI_BOTTOM] < h) ? reg_val[REG_ROI_BOTTOM] : h;
    if (col >= reg_val[REG_ROI_LEFT] && col < re && row >= reg_val[REG_ROI_TOP] && row < be)
      begin
      sx = (int'(r[t]) - int'(l[t])) + 2 * (int'(r[c]) - int'(l[c]))
         + (int'(r[b]) - int'(l[b]));
      sy = (int'(l[b]) + 2 * int'(m[b]) + int'(r[b]))
         - (int'(l[t]) + 2 * int'(m[t]) + int'(r[t]));
      o.pixel_out = root_sat(sx * sx + sy * sy);
    end else begin
      o.pixel_out = m[c];
    end
    o.out_col = col[COL_W-1:0];
    o.out_row = row[ROW_W-1:0];
    o.last_of_run = 1'b0;
    edge_q.push_back(o);
  endtask

  task automatic push_column(pix3_t l, pix3_t m, pix3_t r, int unsigned col,
                             int unsigned row, bit last_row, inout int n);
    if (row >= 1) begin
      push_edge(l, m, r, 0, 1, 2, col, row - 1);
      n++;
    end
    if (last_row) begin
      push_edge(l, m, r, 1, 2, 2, col, row);
      n++;
    end
  endtask

  task automatic predict_pixel(logic [7:0] px, logic fs);
    int unsigned w, h, c, r;
    pix3_t s;
    bit last_row;
    int n;
    n = 0;
    w = eff_dim(reg_val[REG_IMAGE_WIDTH], MAX_WIDTH);
    h = eff_dim(reg_val[REG_IMAGE_HEIGHT], MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    last_row = (r == h - 1);
    if (r == 0) begin
      s[0] = px;
      s[1] = px;
    end else if (r == 1) begin
      s[0] = row_lower[c];
      s[1] = row_lower[c];
    end else begin
      s[0] = row_upper[c];
      s[1] = row_lower[c];
    end
    s[2] = px;
    row_upper[c] = row_lower[c];
    row_lower[c] = px;
    if (c >= 1)
      push_column((c >= 2) ? win_prev : win_cur, win_cur, s, c - 1, r, last_row, n);
    win_prev = win_cur;
    win_cur  = s;
    if (c == w - 1)
      push_column((c >= 1) ? win_prev : win_cur, win_cur, win_cur, c, r, last_row, n);
    if (n > 0) edge_q[$].last_of_run = 1'b1;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c & 32'h7FF;
    row_pos = r & 32'hFFF;
  endtask

  task automatic report(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    err_count++;
  endtask

  // output checker and watchdog sampling
  always @(negedge clk_i) begin
    sem_out_t want;
    moved <= (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (edge_q.size() == 0) begin
        $display("unexpected result at col %0d row %0d", out_data_o.out_col,
                 out_data_o.out_row);
        err_count++;
      end else begin
        want = edge_q.pop_front();
        if (out_data_o.pixel_out !== want.pixel_out)
          report("pixel_out", out_data_o.pixel_out, want.pixel_out);
        if (out_data_o.out_col !== want.out_col)
          report("out_col", out_data_o.out_col, want.out_col);
        if (out_data_o.out_row !== want.out_row)
          report("out_row", out_data_o.out_row, want.out_row);
        if (out_data_o.last_of_run !== want.last_of_run)
          report("last_of_run", out_data_o.last_of_run, want.last_of_run);
      end
    end
  end

  always @(posedge clk_i) begin
    if (moved) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_sobel_edge_magnitude: errors");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] px, logic fs);
    logic rdy;
    if ($urandom_range(99) < in_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{pixel_in: px, frame_start: fs};
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    predict_pixel(px, fs);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // all six registers, written back to back; bit 12 of the 12-bit fields is random
  task automatic setup_frame(int unsigned w, int unsigned h, int unsigned l,
                             int unsigned t, int unsigned r, int unsigned b);
    int unsigned v [6];
    logic [CFG_W-1:0] d;
    v = '{w, h, l, t, r, b};
    drain();
    for (int i = 0; i < 6; i++) begin
      d = CFG_W'(v[i]);
      if (i % 2 == 0) d[12] = 1'($urandom_range(1));
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[CFG_IDX_W-1:0];
      cfg_wdata_i <= d;
      reg_val[i]  = (i % 2 == 0) ? (v[i] & 32'hFFF) : (v[i] & 32'h1FFF);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame(int unsigned count, int fs_noise);
    logic [7:0] px;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(5))
        0: px = 8'h00;
        1: px = 8'hFF;
        default: px = 8'($urandom_range(255));
      endcase
      send_pixel(px, (i == 0) || ($urandom_range(99) < fs_noise));
    end
  endtask

  task automatic test_directed();
    setup_frame(3, 3, 0, 0, 4095, 8191);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'hFF : 8'h00, i == 0);
    setup_frame(0, 0, 0, 0, 2048, 4096);
    send_pixel(8'hA5, 1'b1);
    send_pixel(8'h5A, 1'b0);
    setup_frame(4095, 1, 0, 0, 4095, 8191);
    for (int i = 0; i < 5; i++) send_pixel(8'(i * 63), i == 0);
    setup_frame(2, 8191, 4095, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_pixel(8'(255 - i * 50), i == 0);
  endtask

  task automatic test_roi();
    setup_frame(5, 4, 1, 1, 4, 3);
    send_frame(20, 0);
    setup_frame(4, 3, 3, 2, 1, 1);
    send_frame(12, 0);
    // restart mid-frame with a new frame_start pixel
    setup_frame(4, 4, 0, 0, 4, 4);
    send_frame(6, 0);
    send_frame(10, 0);
  endtask

  task automatic test_random(int unsigned items);
    int unsigned sent, w, h, n;
    sent = 0;
    while (sent < items) begin
      w = $urandom_range(1, 7);
      h = $urandom_range(1, 5);
      setup_frame(w, h, $urandom_range(0, w), $urandom_range(0, h),
                  $urandom_range(0, w + 1), $urandom_range(0, h + 1));
      n = ($urandom_range(3) == 0) ? $urandom_range(1, w * h) : w * h;
      send_frame(n, 3);
      sent += n;
    end
  endtask

  initial begin
    win_cur = '0;
    win_prev = '0;
    col_pos = 0;
    row_pos = 0;
    reg_val = '{640, 480, 0, 0, 2048, 4096};
    foreach (row_upper[i]) begin
      row_upper[i] = '0;
      row_lower[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    in_idle = 14;
    out_idle = 85;
    test_directed();
    test_roi();
    test_random(30);
    in_idle = 85;
    out_idle = 14;
    test_random(30);
    in_idle = 0;
    out_idle = 0;
    test_random(25);
    drain();
    if (err_count == 0) begin
      $display("tb_sobel_edge_magnitude: clean");
    end else begin
      $display("tb_sobel_edge_magnitude: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sem_pkg.sv
hw/rtl/sem_line_ram.sv
hw/rtl/sem_isqrt.sv
hw/rtl/sobel_edge_magnitude.sv
sim/tb_sobel_edge_magnitude.sv
